// ----- sv/cbt3s_pkg.sv -----
// ----------------------------------------------------------------------------
// cbt3s_pkg
// Shared constants and types for the top-three cell balance selector.
// ----------------------------------------------------------------------------
`default_nettype none

package cbt3s_pkg;

    localparam int CELL_COUNT = 6;
    localparam int MV_W       = 15;
    localparam int IDX_W      = 3;
    localparam int MASK_W     = 8;
    localparam int CNT_W      = 4;

    typedef logic signed [MV_W-1:0] mv_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [MASK_W-1:0]      mask_t;

    localparam mv_t  MV_NONE  = mv_t'(-1);
    localparam cnt_t CNT_FULL = cnt_t'(CELL_COUNT);

    // Three best voltages in rank order with their cell indices.
    typedef struct packed {
        mv_t  val0;
        mv_t  val1;
        mv_t  val2;
        idx_t idx0;
        idx_t idx1;
        idx_t idx2;
    } rank_t;

    localparam rank_t RANK_CLEAR = '{
        val0: MV_NONE, val1: MV_NONE, val2: MV_NONE,
        idx0: '0, idx1: '0, idx2: '0
    };

endpackage

`default_nettype wire

// ----- sv/cell_balance_top3_selector_unit.sv -----
// ----------------------------------------------------------------------------
// cell_balance_top3_selector_unit
// Picks the cells to balance from one scan of cell voltages.
// ----------------------------------------------------------------------------
// Each input item carries one cell voltage in signed millivolts, in cell
// order, with last_cell marking the end of a scan. The block keeps the three
// highest voltages of the scan; on a tie the earlier cell keeps its rank.
// Cells beyond the configured cell count are ignored, but their last_cell
// mark still ends the scan.
// The item that ends a scan produces one result item: the balance mask, the
// three ranked indices and the peak voltage. Other items produce nothing.
// An item is registered in the input register on acceptance and ranked
// from there; a final cell's result then goes into the result register.
// One item is taken every cycle unless a final cell waits. When the receiver
// stalls, the result register holds its item; non-final cells still flow
// in, and only a final cell waits in the input register until the result
// register is free.
// Reset clears the ranking (values -1, indices 0) and the cell counter.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_balance_top3_selector_unit
    import cbt3s_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire mv_t   cell_mv,
    input  wire logic  last_cell,
    output logic       out_valid,
    input  wire logic  out_stall,
    output mask_t      balance_mask,
    output idx_t       first_index,
    output idx_t       second_index,
    output idx_t       third_index,
    output mv_t        peak_mv
);

    logic  stage_valid_reg;
    logic  stage_valid_next;
    mv_t   stage_mv_reg;
    logic  stage_last_reg;
    logic  out_valid_reg;
    logic  out_valid_next;
    mask_t mask_reg;
    idx_t  first_reg;
    idx_t  second_reg;
    idx_t  third_reg;
    mv_t   peak_reg;

    logic  advance;
    logic  step;
    logic  emit;
    logic  out_free;
    rank_t ranked;
    mask_t mask_comb;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = !stage_last_reg || out_free;
    assign step     = stage_valid_reg && advance;
    assign emit     = step && stage_last_reg;
    assign in_stall = stage_valid_reg && !advance;

    cbt3s_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cell_mv   (stage_mv_reg),
        .last_cell (stage_last_reg),
        .ranked    (ranked)
    );

    cbt3s_mask u_mask (
        .ranked       (ranked),
        .balance_mask (mask_comb)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (!in_stall)
        begin
            stage_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            stage_mv_reg   <= cell_mv;
            stage_last_reg <= last_cell;
        end
        if (emit)
        begin
            mask_reg   <= mask_comb;
            first_reg  <= ranked.idx0;
            second_reg <= ranked.idx1;
            third_reg  <= ranked.idx2;
            peak_reg   <= ranked.val0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign balance_mask = mask_reg;
    assign first_index  = first_reg;
    assign second_index = second_reg;
    assign third_index  = third_reg;
    assign peak_mv      = peak_reg;

endmodule

`default_nettype wire

// ----- sv/cbt3s_tracker.sv -----
// ----------------------------------------------------------------------------
// cbt3s_tracker
// Holds the running top three of the current scan and inserts one cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cbt3s_tracker
    import cbt3s_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step,
    input  wire mv_t   cell_mv,
    input  wire logic  last_cell,
    output rank_t      ranked
);

    cnt_t  cnt_reg;
    cnt_t  cnt_next;
    rank_t rank_reg;
    rank_t rank_next;
    idx_t  idx;
    logic  taking;

    assign idx    = cnt_reg[IDX_W-1:0];
    assign taking = (cnt_reg < CNT_FULL);

    // Ranking as it stands once the presented cell is inserted.
    always_comb
    begin
        ranked = rank_reg;
        if (taking)
        begin
            if (cell_mv > rank_reg.val0)
            begin
                ranked.val2 = rank_reg.val1;
                ranked.idx2 = rank_reg.idx1;
                ranked.val1 = rank_reg.val0;
                ranked.idx1 = rank_reg.idx0;
                ranked.val0 = cell_mv;
                ranked.idx0 = idx;
            end
            else if (cell_mv > rank_reg.val1)
            begin
                ranked.val2 = rank_reg.val1;
                ranked.idx2 = rank_reg.idx1;
                ranked.val1 = cell_mv;
                ranked.idx1 = idx;
            end
            else if (cell_mv > rank_reg.val2)
            begin
                ranked.val2 = cell_mv;
                ranked.idx2 = idx;
            end
        end
    end

    always_comb
    begin
        rank_next = rank_reg;
        cnt_next  = cnt_reg;
        if (step)
        begin
            if (last_cell)
            begin
                rank_next = RANK_CLEAR;
                cnt_next  = '0;
            end
            else
            begin
                rank_next = ranked;
                if (taking)
                begin
                    cnt_next = cnt_reg + cnt_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            rank_reg <= RANK_CLEAR;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            rank_reg <= rank_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/cbt3s_mask.sv -----
// ----------------------------------------------------------------------------
// cbt3s_mask
// Builds the balance mask from the three ranked indices.
// ----------------------------------------------------------------------------
`default_nettype none

module cbt3s_mask
    import cbt3s_pkg::*;
(
    input  wire rank_t ranked,
    output mask_t      balance_mask
);

    function automatic logic apart(input idx_t a, input idx_t b);
        idx_t d;
        begin
            d = (a > b) ? (a - b) : (b - a);
            apart = (d > idx_t'(1));
        end
    endfunction

    logic ap01;
    logic ap20;
    logic ap21;

    assign ap01 = apart(ranked.idx0, ranked.idx1);
    assign ap20 = apart(ranked.idx2, ranked.idx0);
    assign ap21 = apart(ranked.idx2, ranked.idx1);

    // The third cell is only checked against cells that were actually chosen.
    always_comb
    begin
        balance_mask = mask_t'(1) << ranked.idx0;
        if (ap01)
        begin
            balance_mask = balance_mask | (mask_t'(1) << ranked.idx1);
            if (ap20 && ap21)
            begin
                balance_mask = balance_mask | (mask_t'(1) << ranked.idx2);
            end
        end
        else if (ap20)
        begin
            balance_mask = balance_mask | (mask_t'(1) << ranked.idx2);
        end
    end

endmodule

`default_nettype wire
